@@ rtl/core/bbc_pkg.sv @@
// Shared constants, codes and types for the bitplane blit and collision block.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int ROW_BITS   = 32;
  localparam int MAX_COLUMN = 30;

  localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HEIGHT_W   = $clog2(MAX_ROWS + 1);
  localparam int CMP_W      = (HEIGHT_W > 9) ? HEIGHT_W : 9;

  localparam int OPCODE_W   = 3;
  localparam int BASE_ROW_W = 8;
  localparam int COL_W      = 6;
  localparam int SRC_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int ROWS_CFG_W = 6;
  localparam int OFFSET_W   = 6;
  localparam int TARGET_W   = BASE_ROW_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(MAX_ROWS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR_GRID = 3'd0,
    OP_SET_CELL   = 3'd1,
    OP_CLEAR_CELL = 3'd2,
    OP_OR_ROW     = 3'd3,
    OP_BIC_ROW    = 3'd4,
    OP_TEST_ROW   = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_COL  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Work handed from the front to the back.
  typedef enum logic [2:0] {
    ACT_NOP      = 3'd0,
    ACT_CLEAR    = 3'd1,
    ACT_SET_BITS = 3'd2,
    ACT_CLR_BITS = 3'd3,
    ACT_TEST     = 3'd4
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [ROW_IDX_W-1:0]  row_idx;
    logic [ROW_BITS-1:0]   mask;
    status_t               status;
    logic                  run_end;
  } entry_t;

endpackage

@@ rtl/core/bbc_front.sv @@
// Front end: holds the row count and run offset, classifies each input word.
`timescale 1ns / 1ps

module bbc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bbc_pkg::ROWS_CFG_W-1:0]    cfg_rows_in_use,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bbc_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic signed [bbc_pkg::BASE_ROW_W-1:0] in_base_row,
  input  logic signed [bbc_pkg::COL_W-1:0]  in_col_or_shift,
  input  logic [bbc_pkg::SRC_W-1:0]         in_source_row,
  input  logic                              in_last,
  output logic                              q_valid,
  input  logic                              q_ready,
  output bbc_pkg::entry_t                   q_entry
);

  logic [bbc_pkg::ROWS_CFG_W-1:0] rows_r, rows_nxt;
  logic [bbc_pkg::OFFSET_W-1:0]   offset_r, offset_nxt;

  logic                           accept;
  logic [bbc_pkg::CMP_W-1:0]      height;
  logic [bbc_pkg::TARGET_W-1:0]   target;
  logic                           target_in;
  logic                           cell_in;
  logic                           col_bad;
  logic [bbc_pkg::COL_W-1:0]      shift_mag;
  logic [bbc_pkg::ROW_BITS-1:0]   src_row;
  logic [bbc_pkg::ROW_BITS-1:0]   shifted;
  logic [bbc_pkg::ROW_BITS-1:0]   cell_bit;
  logic                           is_run_op;
  bbc_pkg::entry_t                entry;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;
  assign q_entry  = entry;

  always_comb begin
    // Saturate the row count at the grid height.
    if (bbc_pkg::CMP_W'(rows_r) > bbc_pkg::CMP_W'(bbc_pkg::MAX_ROWS)) begin
      height = bbc_pkg::CMP_W'(bbc_pkg::MAX_ROWS);
    end else begin
      height = bbc_pkg::CMP_W'(rows_r);
    end
    target    = {in_base_row[bbc_pkg::BASE_ROW_W-1], in_base_row} +
                bbc_pkg::TARGET_W'(offset_r);
    target_in = !target[bbc_pkg::TARGET_W-1] &&
                (bbc_pkg::CMP_W'(target[bbc_pkg::TARGET_W-2:0]) < height);
    cell_in   = !in_base_row[bbc_pkg::BASE_ROW_W-1] &&
                (bbc_pkg::CMP_W'(in_base_row[bbc_pkg::BASE_ROW_W-2:0]) < height);
    col_bad   = in_col_or_shift[bbc_pkg::COL_W-1] ||
                (bbc_pkg::COL_W'(in_col_or_shift) > bbc_pkg::COL_W'(bbc_pkg::MAX_COLUMN));
    shift_mag = in_col_or_shift[bbc_pkg::COL_W-1] ? (~in_col_or_shift + 1'b1)
                                                   : in_col_or_shift;
    src_row   = bbc_pkg::ROW_BITS'(in_source_row);
    if (in_col_or_shift[bbc_pkg::COL_W-1]) begin
      shifted = src_row >> shift_mag;
    end else begin
      shifted = src_row << shift_mag;
    end
    cell_bit  = bbc_pkg::ROW_BITS'(1) << in_col_or_shift[bbc_pkg::COL_W-2:0];
  end

  always_comb begin
    entry         = '0;
    entry.action  = bbc_pkg::ACT_NOP;
    entry.status  = bbc_pkg::ST_OK;
    is_run_op     = 1'b0;
    case (in_opcode)
      bbc_pkg::OP_CLEAR_GRID: begin
        entry.action = bbc_pkg::ACT_CLEAR;
      end
      bbc_pkg::OP_SET_CELL, bbc_pkg::OP_CLEAR_CELL: begin
        entry.row_idx = bbc_pkg::ROW_IDX_W'(in_base_row[bbc_pkg::BASE_ROW_W-2:0]);
        entry.mask    = cell_bit;
        if (col_bad) begin
          entry.status = bbc_pkg::ST_BAD_COL;
        end else if (!cell_in) begin
          entry.status = bbc_pkg::ST_OVERFLOW;
        end else if (in_opcode == bbc_pkg::OP_SET_CELL) begin
          entry.action = bbc_pkg::ACT_SET_BITS;
        end else begin
          entry.action = bbc_pkg::ACT_CLR_BITS;
        end
      end
      bbc_pkg::OP_OR_ROW, bbc_pkg::OP_BIC_ROW: begin
        is_run_op     = 1'b1;
        entry.row_idx = bbc_pkg::ROW_IDX_W'(target[bbc_pkg::TARGET_W-2:0]);
        entry.mask    = shifted;
        entry.run_end = in_last;
        if (target_in) begin
          entry.action = (in_opcode == bbc_pkg::OP_OR_ROW) ? bbc_pkg::ACT_SET_BITS
                                                           : bbc_pkg::ACT_CLR_BITS;
        end else if (|shifted) begin
          entry.status = bbc_pkg::ST_OVERFLOW;
        end
      end
      bbc_pkg::OP_TEST_ROW: begin
        is_run_op     = 1'b1;
        entry.action  = bbc_pkg::ACT_TEST;
        entry.row_idx = bbc_pkg::ROW_IDX_W'(target[bbc_pkg::TARGET_W-2:0]);
        // Out-of-range rows test against nothing.
        entry.mask    = target_in ? shifted : '0;
        entry.run_end = in_last;
      end
      default: begin
        entry.action = bbc_pkg::ACT_NOP;
      end
    endcase
  end

  always_comb begin
    rows_nxt   = cfg_wr_en ? cfg_rows_in_use : rows_r;
    offset_nxt = offset_r;
    if (accept && is_run_op) begin
      offset_nxt = in_last ? '0 : offset_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= bbc_pkg::ROWS_RESET;
      offset_r <= '0;
    end else begin
      rows_r   <= rows_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

@@ rtl/core/bbc_queue.sv @@
// Short FIFO of classified work between the front and the back.
`timescale 1ns / 1ps

module bbc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  bbc_pkg::entry_t wr_entry,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bbc_pkg::entry_t rd_entry
);

  bbc_pkg::entry_t                 slot_r [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::QPTR_W-1:0]      wptr_r, wptr_nxt;
  logic [bbc_pkg::QPTR_W-1:0]      rptr_r, rptr_nxt;
  logic [bbc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            push, pop;

  assign wr_ready = (cnt_r != bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + bbc_pkg::QCNT_W'(push) - bbc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_entry;
    end
  end

endmodule

@@ rtl/core/bbc_back.sv @@
// Back end: owns the grid, applies row updates and tests, drives results.
`timescale 1ns / 1ps

module bbc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  bbc_pkg::entry_t                q_entry,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [bbc_pkg::STATUS_W-1:0]   out_status
);

  logic [bbc_pkg::ROW_BITS-1:0]  grid_r [bbc_pkg::MAX_ROWS];
  logic [bbc_pkg::ROW_BITS-1:0]  row_cur;
  logic [bbc_pkg::ROW_BITS-1:0]  row_new;
  logic                          hit_r, hit_nxt;
  logic                          hit_now;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r;
  logic [bbc_pkg::STATUS_W-1:0]  out_status_r;
  logic                          pop;

  assign q_ready    = !out_valid_r || out_ready;
  assign pop        = q_valid && q_ready;
  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

  always_comb begin
    row_cur = grid_r[q_entry.row_idx];
    hit_now = hit_r || (|(row_cur & q_entry.mask));
    case (q_entry.action)
      bbc_pkg::ACT_SET_BITS: row_new = row_cur | q_entry.mask;
      bbc_pkg::ACT_CLR_BITS: row_new = row_cur & ~q_entry.mask;
      default:               row_new = row_cur;
    endcase
    hit_nxt = hit_r;
    if (pop) begin
      if (q_entry.run_end) begin
        hit_nxt = 1'b0;
      end else if (q_entry.action == bbc_pkg::ACT_TEST) begin
        hit_nxt = hit_now;
      end
    end
    out_valid_nxt = pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bbc_pkg::MAX_ROWS; i++) begin
        grid_r[i] <= '0;
      end
    end else begin
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (q_entry.action == bbc_pkg::ACT_CLEAR) begin
          for (int i = 0; i < bbc_pkg::MAX_ROWS; i++) begin
            grid_r[i] <= '0;
          end
        end else begin
          grid_r[q_entry.row_idx] <= row_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_hit_r    <= (q_entry.action == bbc_pkg::ACT_TEST) ? hit_now : 1'b0;
      out_status_r <= q_entry.status;
    end
  end

endmodule

@@ rtl/core/bitplane_blit_and_collision.sv @@
// Top level of the bitplane blit and collision block.
// Path: an accepted input word is written into the queue, then into the output
//   register, where out_valid marks the result word ready to be taken.
// Throughput: one word per cycle with out_ready high; the back end does one grid row
//   read-modify-write per cycle, and a two-word queue decouples it from the front end.
// Reset (rst_n, synchronous, active low): grid all zero, run offset and hit flag
//   zero, rows in use 32, queue and output register empty.
`timescale 1ns / 1ps

module bitplane_blit_and_collision (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration: rows in use (matrix height).
  input  logic                                  cfg_wr_en,
  input  logic [bbc_pkg::ROWS_CFG_W-1:0]        cfg_rows_in_use,
  // Input words.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bbc_pkg::OPCODE_W-1:0]          in_opcode,
  input  logic signed [bbc_pkg::BASE_ROW_W-1:0] in_base_row,
  input  logic signed [bbc_pkg::COL_W-1:0]      in_col_or_shift,
  input  logic [bbc_pkg::SRC_W-1:0]             in_source_row,
  input  logic                                  in_last,
  // Result words.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_hit,
  output logic [bbc_pkg::STATUS_W-1:0]          out_status
);

  // Front to queue.
  logic            fq_valid;
  logic            fq_ready;
  bbc_pkg::entry_t fq_entry;

  // Queue to back.
  logic            qb_valid;
  logic            qb_ready;
  bbc_pkg::entry_t qb_entry;

  // Front: decode the opcode, form the target row (base plus run offset), range
  // check it against the saturated row count, shift the source row, and settle
  // the status. The run offset advances here, in accept order, so the back end
  // never needs it.
  bbc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_rows_in_use (cfg_rows_in_use),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_base_row     (in_base_row),
    .in_col_or_shift (in_col_or_shift),
    .in_source_row   (in_source_row),
    .in_last         (in_last),
    .q_valid         (fq_valid),
    .q_ready         (fq_ready),
    .q_entry         (fq_entry)
  );

  // Hold classified work while the back end waits on the result side.
  bbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_entry (fq_entry),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_entry (qb_entry)
  );

  // Back: apply the mask to the grid row or test it, track the run's hit flag,
  // and register the result word. A new entry is taken while the previous
  // result is being handed off.
  bbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_entry    (qb_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_status (out_status)
  );

endmodule
